// ===== rtl/core/cfbc_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the framed blob checker.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package cfbc_pkg;

  // Frame format
  localparam int MAX_PAYLOAD  = 4085;
  localparam int HEADER_BYTES = 11;
  localparam int LEN_W        = 12;  // payload length width, holds MAX_PAYLOAD
  localparam int POS_W        = 12;  // header index or payload byte count
  localparam int CAP_W        = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

  localparam logic [7:0] MAGIC_S = 8'h53;
  localparam logic [7:0] MAGIC_M = 8'h4D;
  localparam logic [7:0] MAGIC_K = 8'h4B;
  localparam logic [7:0] VERSION = 8'h01;

  // Header byte positions
  localparam logic [POS_W-1:0] POS_MAGIC0  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_MAGIC1  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_MAGIC2  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_MAGIC3  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_VERSION = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_CRC0    = POS_W'(7);
  localparam logic [POS_W-1:0] POS_CRC1    = POS_W'(8);
  localparam logic [POS_W-1:0] POS_CRC2    = POS_W'(9);
  localparam logic [POS_W-1:0] POS_CRC3    = POS_W'(HEADER_BYTES - 1);

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    VERDICT_OK         = 2'd0,
    VERDICT_BAD_HEADER = 2'd1,
    VERDICT_BAD_LENGTH = 2'd2,
    VERDICT_BAD_CRC    = 2'd3
  } verdict_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic             frame_done;
    logic [1:0]       verdict;
    logic [LEN_W-1:0] payload_length;
  } out_item_t;

  // Reflected CRC-32 over one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cfbc_in_reg.sv =====
// Input register for the framed blob checker: holds one accepted beat until
// the parser consumes it. Depends on cfbc_pkg.
`default_nettype none

module cfbc_in_reg
  import cfbc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     advance,
  output logic          item_valid,
  output in_item_t      item
);

  logic take;

  assign in_stall = item_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cfbc_parser.sv =====
// Frame parser and CRC-32 datapath: header checks, length checks, byte-wide
// CRC update and verdict. Holds the capacity register. Depends on cfbc_pkg.
`default_nettype none

module cfbc_parser
  import cfbc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire logic             step,
  input  wire in_item_t         item,
  output logic                  has_result,
  output out_item_t             result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_BODY
  } phase_t;

  phase_t           phase, phase_next, eff_phase;
  logic [POS_W-1:0] pos, pos_next, eff_pos;
  logic [31:0]      crc, crc_next, eff_crc;
  logic [31:0]      exp_crc, exp_crc_next, eff_exp;
  logic [LEN_W-1:0] len, len_next, eff_len;
  logic [CAP_W-1:0] capacity;

  logic             bad;
  logic [15:0]      full_len;
  logic             crc_ok;
  logic [7:0]       b;

  assign b = item.data_byte;

  always_comb begin
    eff_phase = phase;
    eff_pos   = pos;
    eff_crc   = crc;
    eff_exp   = exp_crc;
    eff_len   = len;
    // A frame start restarts the parser in any phase
    if (item.frame_start) begin
      eff_phase = PH_HEAD;
      eff_pos   = '0;
      eff_crc   = CRC_ONES;
      eff_exp   = '0;
      eff_len   = '0;
    end

    phase_next   = eff_phase;
    pos_next     = eff_pos;
    crc_next     = eff_crc;
    exp_crc_next = eff_exp;
    len_next     = eff_len;
    has_result   = 1'b0;
    result       = '0;
    bad          = 1'b0;
    crc_ok       = 1'b0;
    full_len     = {b, eff_len[7:0]};

    case (eff_phase)
      PH_HEAD: begin
        case (eff_pos)
          POS_MAGIC0:  bad = (b != MAGIC_S);
          POS_MAGIC1:  bad = (b != MAGIC_M);
          POS_MAGIC2:  bad = (b != MAGIC_K);
          POS_MAGIC3:  bad = (b != MAGIC_M);
          POS_VERSION: bad = (b != VERSION);
          POS_LEN_LO:  len_next = LEN_W'(b);
          POS_LEN_HI:  len_next = full_len[LEN_W-1:0];
          POS_CRC0:    exp_crc_next[7:0]   = b;
          POS_CRC1:    exp_crc_next[15:8]  = b;
          POS_CRC2:    exp_crc_next[23:16] = b;
          POS_CRC3:    exp_crc_next[31:24] = b;
          default:     bad = 1'b0;
        endcase

        if (bad) begin
          phase_next        = PH_IDLE;
          has_result        = 1'b1;
          result.frame_done = 1'b1;
          result.verdict    = VERDICT_BAD_HEADER;
        end else if (eff_pos == POS_LEN_HI &&
                     (full_len > 16'(MAX_PAYLOAD) ||
                      {1'b0, full_len} + 17'd1 > {1'b0, capacity})) begin
          phase_next        = PH_IDLE;
          has_result        = 1'b1;
          result.frame_done = 1'b1;
          result.verdict    = VERDICT_BAD_LENGTH;
        end else if (eff_pos == POS_CRC3) begin
          pos_next   = '0;
          phase_next = PH_BODY;
          // Empty payload: CRC of nothing is zero
          if (len_next == '0) begin
            phase_next        = PH_IDLE;
            has_result        = 1'b1;
            result.frame_done = 1'b1;
            result.verdict    = (exp_crc_next == '0) ? VERDICT_OK : VERDICT_BAD_CRC;
          end
        end else begin
          pos_next = eff_pos + POS_W'(1);
        end
      end

      PH_BODY: begin
        crc_next             = crc_byte(eff_crc, b);
        pos_next             = eff_pos + POS_W'(1);
        has_result           = 1'b1;
        result.payload_valid = 1'b1;
        result.payload_byte  = b;
        if (pos_next >= eff_len) begin
          crc_ok                = ((crc_next ^ CRC_ONES) == eff_exp);
          phase_next            = PH_IDLE;
          result.frame_done     = 1'b1;
          result.verdict        = crc_ok ? VERDICT_OK : VERDICT_BAD_CRC;
          result.payload_length = crc_ok ? eff_len : '0;
        end
      end

      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      pos     <= '0;
      crc     <= CRC_ONES;
      exp_crc <= '0;
      len     <= '0;
    end else if (step) begin
      phase   <= phase_next;
      pos     <= pos_next;
      crc     <= crc_next;
      exp_crc <= exp_crc_next;
      len     <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cfbc_out_reg.sv =====
// Result register for the framed blob checker: holds one result beat until
// the consumer takes it. Depends on cfbc_pkg.
`default_nettype none

module cfbc_out_reg
  import cfbc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_item_t result,
  output logic           slot_free,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  // Free when empty or emptying this cycle
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crc32_framed_blob_checker_top.sv =====
// Top level of the framed blob checker: input register, parser and result register.
// Depends on cfbc_pkg, cfbc_in_reg, cfbc_parser and cfbc_out_reg.
`default_nettype none

// Checks a stored frame one byte per beat: an 11-byte header (magic S M K M, version 1,
// 16-bit little-endian payload length, 32-bit little-endian CRC) then the payload.
// Each accepted byte is parsed from the input register and its result, if any, lands in
// the result register; one byte per cycle is sustained while no result waits in a stalled
// result register, with the input register and the result register between input beat
// and result beat; the byte-wide CRC-32 update is combinational between them. Payload bytes are
// forwarded before the verdict, so drop them on a failing verdict. A byte that makes a
// result holds while an earlier result waits in a stalled result register; bytes that
// produce no result keep flowing meanwhile.
// Write cfg_data (buffer capacity, reset 4096) only while the block is idle.
module crc32_framed_blob_checker_top
  import cfbc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data
);

  logic      item_valid;
  in_item_t  item;
  logic      advance;
  logic      has_result;
  out_item_t result;
  logic      slot_free;

  // Advance unless a result would land in a full, stalled slot
  assign advance = item_valid && (!has_result || slot_free);

  cfbc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cfbc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .step       (advance),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  cfbc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .result    (result),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for crc32_framed_blob_checker_top: directed frames, capacity sweeps,
// output hold-off and random framed traffic, all scored against an in-bench frame parser.
// Depends on cfbc_pkg and the RTL of the block only.
`default_nettype none

module tb;
  import cfbc_pkg::*;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_HEADER,
    PARSE_PAYLOAD
  } parse_phase_t;

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic [CAP_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;

  crc32_framed_blob_checker_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Parser state mirrored in the bench
  parse_phase_t     phase;
  logic [POS_W-1:0] hdr_pos;
  logic [31:0]      crc_run;
  logic [31:0]      crc_stored;
  logic [15:0]      len_hdr;
  logic [CAP_W-1:0] capacity;

  out_item_t   result_q[$];
  out_item_t   exp_r;
  int unsigned failures;
  int unsigned results_checked;
  int unsigned beats_sent;
  int unsigned frames_sent;
  int unsigned cap_writes;

  logic        tx_gaps;
  logic        rx_gaps;
  int unsigned rx_hold;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
    for (int k = 0; k < 8; k++) begin
      logic fb;
      fb = c[0] ^ d[k];
      c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic string fmt(input out_item_t r);
    return $sformatf("pv=%0b byte=%02h done=%0b verdict=%0d len=%0d",
                     r.payload_valid, r.payload_byte, r.frame_done, r.verdict, r.payload_length);
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("ERROR: %s", msg);
  endtask

  function automatic void close_frame(inout out_item_t r);
    phase = PARSE_IDLE;
    r.frame_done = 1'b1;
    if ((crc_run ^ CRC_ONES) == crc_stored) begin
      r.verdict        = VERDICT_OK;
      r.payload_length = len_hdr[LEN_W-1:0];
    end else begin
      r.verdict = VERDICT_BAD_CRC;
    end
  endfunction

  // Advance the mirrored parser by one accepted byte and queue the result it causes
  task automatic parse_frame_byte(input in_item_t it);
    out_item_t r;
    logic      bad;
    logic      emits;
    r     = '0;
    emits = 1'b0;
    bad   = 1'b0;
    if (it.frame_start) begin
      phase      = PARSE_HEADER;
      hdr_pos    = '0;
      crc_run    = CRC_ONES;
      crc_stored = '0;
      len_hdr    = '0;
    end
    case (phase)
      PARSE_HEADER: begin
        case (hdr_pos)
          POS_MAGIC0:             bad = it.data_byte != MAGIC_S;
          POS_MAGIC1, POS_MAGIC3: bad = it.data_byte != MAGIC_M;
          POS_MAGIC2:             bad = it.data_byte != MAGIC_K;
          POS_VERSION:            bad = it.data_byte != VERSION;
          default:                bad = 1'b0;
        endcase
        if (bad) begin
          phase       = PARSE_IDLE;
          r.frame_done = 1'b1;
          r.verdict    = VERDICT_BAD_HEADER;
          emits        = 1'b1;
        end else begin
          if (hdr_pos == POS_LEN_LO) begin
            len_hdr = {8'd0, it.data_byte};
          end else if (hdr_pos == POS_LEN_HI) begin
            len_hdr[15:8] = it.data_byte;
            if (len_hdr > MAX_PAYLOAD || len_hdr + 1 > capacity) begin
              phase        = PARSE_IDLE;
              r.frame_done = 1'b1;
              r.verdict    = VERDICT_BAD_LENGTH;
              emits        = 1'b1;
            end
          end else if (hdr_pos >= POS_CRC0) begin
            crc_stored |= {24'd0, it.data_byte} << (8 * (hdr_pos - POS_CRC0));
          end
          if (phase == PARSE_HEADER) begin
            hdr_pos = hdr_pos + 1'b1;
            if (hdr_pos >= HEADER_BYTES) begin
              hdr_pos = '0;
              phase   = PARSE_PAYLOAD;
              if (len_hdr == 0) begin
                close_frame(r);
                emits = 1'b1;
              end
            end
          end
        end
      end
      PARSE_PAYLOAD: begin
        crc_run         = crc_step(crc_run, it.data_byte);
        hdr_pos         = hdr_pos + 1'b1;
        r.payload_valid = 1'b1;
        r.payload_byte  = it.data_byte;
        emits           = 1'b1;
        if (hdr_pos >= len_hdr) close_frame(r);
      end
      default: ;
    endcase
    if (emits) result_q.push_back(r);
  endtask

  // Offer one beat, hold it until accepted, then step the parser
  task automatic send_byte(input logic start, input logic [7:0] b);
    in_item_t it;
    it.frame_start = start;
    it.data_byte   = b;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    parse_frame_byte(it);
    beats_sent++;
    @(negedge clk);
  endtask

  // Header plus payload; crc_flip corrupts the stored CRC, bad_pos spoils one magic or
  // version byte, cut stops the frame early, fill < 0 means random payload bytes
  task automatic send_frame(input logic [15:0] len, input logic [31:0] crc_flip,
                            input int bad_pos, input int cut, input int fill);
    logic [7:0]  fb[$];
    logic [7:0]  pl[$];
    logic [31:0] c;
    int          n;
    n = (len > MAX_PAYLOAD) ? 4 : int'(len);
    c = CRC_ONES;
    for (int k = 0; k < n; k++) begin
      pl.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      c = crc_step(c, pl[k]);
    end
    c  = c ^ CRC_ONES ^ crc_flip;
    fb = '{MAGIC_S, MAGIC_M, MAGIC_K, MAGIC_M, VERSION, len[7:0], len[15:8],
           c[7:0], c[15:8], c[23:16], c[31:24]};
    if (bad_pos >= 0) fb[bad_pos] = fb[bad_pos] ^ 8'($urandom_range(1, 255));
    fb = {fb, pl};
    n  = (cut >= 0 && cut < fb.size()) ? cut : fb.size();
    for (int k = 0; k < n; k++) send_byte(k == 0, fb[k]);
    frames_sent++;
  endtask

  // Drop valid and wait until every queued result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    capacity = v;
    cap_writes++;
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = gap_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (result_q.size() == 0) begin
        note_failure($sformatf("unexpected result %s", fmt(out_data)));
      end else begin
        exp_r = result_q.pop_front();
        if (out_data.payload_valid  !== exp_r.payload_valid  ||
            out_data.payload_byte   !== exp_r.payload_byte   ||
            out_data.frame_done     !== exp_r.frame_done     ||
            out_data.verdict        !== exp_r.verdict        ||
            out_data.payload_length !== exp_r.payload_length)
          note_failure($sformatf("result %0d: expected %s, got %s",
                                 results_checked, fmt(exp_r), fmt(out_data)));
      end
      results_checked++;
    end
  end

  task automatic test_idle_bytes();
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, MAGIC_S);
  endtask

  task automatic test_good_frames();
    send_frame(16'd0, 32'd0, -1, -1, -1);
    send_frame(16'd1, 32'd0, -1, -1, 8'h00);
    send_frame(16'd3, 32'd0, -1, -1, 8'hFF);
    send_frame(16'd16, 32'd0, -1, -1, -1);
    send_byte(1'b0, 8'hA5);  // ignored after the verdict
  endtask

  task automatic test_header_errors();
    for (int p = 0; p <= 4; p++) send_frame(16'd2, 32'd0, p, -1, -1);
  endtask

  task automatic test_length_errors();
    send_frame(16'(MAX_PAYLOAD + 1), 32'd0, -1, -1, -1);
    send_frame(16'hFFFF, 32'd0, -1, -1, -1);
    send_frame(16'd4095, 32'd0, -1, -1, -1);
  endtask

  task automatic test_crc_errors();
    send_frame(16'd5, 32'h0000_0001, -1, -1, -1);
    send_frame(16'd0, 32'h8000_0000, -1, -1, -1);
    send_frame(16'd9, 32'hFFFF_FFFF, -1, -1, 8'h00);
  endtask

  task automatic test_restart();
    send_frame(16'd4, 32'd0, -1, 6, -1);   // cut in the header
    send_frame(16'd8, 32'd0, -1, 14, -1);  // cut in the payload
    send_frame(16'd4, 32'd0, -1, -1, -1);
  endtask

  task automatic test_capacity_limits();
    set_capacity(16'd0);
    send_frame(16'd0, 32'd0, -1, -1, -1);
    send_frame(16'd5, 32'd0, -1, -1, -1);
    set_capacity(16'd1);
    send_frame(16'd0, 32'd0, -1, -1, -1);
    send_frame(16'd1, 32'd0, -1, -1, -1);
    set_capacity(16'd17);
    send_frame(16'd16, 32'd0, -1, -1, -1);
    send_frame(16'd17, 32'd0, -1, -1, -1);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_capacity(16'hFFFF);
    // Longest legal length passes the length check; cut early and restart
    send_frame(16'(MAX_PAYLOAD), 32'd0, -1, 14, -1);
    send_frame(16'(MAX_PAYLOAD + 1), 32'd0, -1, -1, -1);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_output_hold();
    drain();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    rx_hold = 80;
    send_frame(16'd40, 32'd0, -1, -1, -1);
    drain();
    send_frame(16'd7, 32'd0, -1, -1, -1);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned max_ok;
    int unsigned len;
    logic [31:0] flip;
    tx_gaps = $urandom_range(0, 4) != 0;
    rx_gaps = $urandom_range(0, 4) != 0;
    max_ok  = (capacity == 0) ? 0 : ((capacity > MAX_PAYLOAD) ? MAX_PAYLOAD : capacity - 1);
    len     = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
    if (len > max_ok) len = $urandom_range(0, max_ok);
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      send_frame(16'(len), 32'd0, -1, -1, -1);
    end else if (kind < 80) begin
      flip = $urandom;
      if (flip == 0) flip = 32'd1;
      send_frame(16'(len), flip, -1, -1, -1);
    end else if (kind < 87) begin
      send_frame(16'(len), 32'd0, $urandom_range(0, 4), -1, -1);
    end else if (kind < 93) begin
      if (capacity <= 64 && $urandom_range(0, 1) == 0)
        send_frame(capacity, 32'd0, -1, -1, -1);
      else
        send_frame(16'($urandom_range(MAX_PAYLOAD + 1, 65535)), 32'd0, -1, -1, -1);
    end else if (kind < 97) begin
      send_frame(16'(len), 32'd0, -1, $urandom_range(1, 10 + len), -1);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 7) == 0, 8'($urandom));
    end
    if ($urandom_range(0, 5) == 0) send_byte(1'b0, 8'($urandom));
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    for (int s = 0; s < 4; s++) begin
      if (s > 0)
        set_capacity(($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 40))
                                                 : 16'($urandom_range(0, 65535)));
      stop_at = beats_sent + 20;
      while (beats_sent < stop_at) send_random_frame();
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_write  = 1'b0;
    cfg_data   = '0;
    out_stall  = 1'b0;
    tx_gaps    = 1'b1;
    rx_gaps    = 1'b1;
    rx_hold    = 0;
    stall_left = 0;
    phase      = PARSE_IDLE;
    hdr_pos    = '0;
    crc_run    = CRC_ONES;
    crc_stored = '0;
    len_hdr    = '0;
    capacity   = CAP_RESET;
    failures        = 0;
    results_checked = 0;
    beats_sent      = 0;
    frames_sent     = 0;
    cap_writes      = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_bytes();
    test_good_frames();
    test_header_errors();
    test_length_errors();
    test_crc_errors();
    test_restart();
    test_capacity_limits();
    test_output_hold();
    test_random_traffic();

    drain();
    repeat (8) @(negedge clk);
    if (result_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", result_q.size()));
    $display("Sent %0d beats in %0d frames over %0d capacity writes; %0d results checked.",
             beats_sent, frames_sent, cap_writes, results_checked);
    $display("Covered good, bad header, bad length, bad CRC, restart and noise; %0d errors.",
             failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/cfbc_pkg.sv
rtl/core/cfbc_in_reg.sv
rtl/core/cfbc_parser.sv
rtl/core/cfbc_out_reg.sv
rtl/core/crc32_framed_blob_checker_top.sv
tb/tb.sv
